FILE: rtl/pph_pkg.sv
// Shared types, codes and constants of the per-position quality histogram.
package pph_pkg;

  localparam int DEF_MAX_POSITIONS = 512;
  localparam int DEF_SCORE_BINS    = 64;
  localparam int DEF_COUNT_WIDTH   = 32;

  localparam int POS_W          = 9;
  localparam int QCH_W          = 8;
  localparam int BIN_W          = 7;   // holds a bin index for up to 128 bins
  localparam int OFFSET_W       = 7;
  localparam int RESULT_COUNT_W = 32;
  localparam int READ_TOTAL_W   = 40;
  localparam int LONGEST_W      = 10;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 7'd33;

  localparam logic [1:0] ACT_BASE     = 2'd0;
  localparam logic [1:0] ACT_READ_END = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_READ_END,
    OP_QUERY
  } op_kind_t;

  typedef struct packed {
    logic [1:0]       action;
    logic             mate;
    logic [POS_W-1:0] position;
    logic [QCH_W-1:0] quality_char;
  } in_t;

  typedef struct packed {
    logic [RESULT_COUNT_W-1:0] bin_count;
    logic [READ_TOTAL_W-1:0]   read_total;
    logic [LONGEST_W-1:0]      longest_read;
    logic                      paired_seen;
  } out_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    op_kind_t         kind;
    logic             mate;
    logic [POS_W-1:0] position;
    logic [BIN_W-1:0] bin;
    logic             hit;   // query falls inside the store
  } op_t;

endpackage

FILE: rtl/pph_front.sv
// Front end: takes input beats, holds the offset register and classifies items.
module pph_front #(
  parameter int MAX_POSITIONS = pph_pkg::DEF_MAX_POSITIONS,
  parameter int SCORE_BINS    = pph_pkg::DEF_SCORE_BINS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pph_pkg::in_t                   in_data,
  input  logic                           cfg_write,
  input  logic [pph_pkg::OFFSET_W-1:0]   cfg_data,
  input  logic                           clearing,
  input  logic                           queue_full,
  output logic                           push,
  output pph_pkg::op_t                   push_op
);
  import pph_pkg::*;

  logic [OFFSET_W-1:0] quality_offset;
  logic [QCH_W:0]      diff;
  logic [BIN_W-1:0]    base_bin;
  logic                pos_ok;
  logic                bin_ok;
  logic                keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_offset <= OFFSET_RESET;
    end else if (cfg_write) begin
      quality_offset <= cfg_data;
    end
  end

  always_comb begin
    diff   = {1'b0, in_data.quality_char} - (QCH_W + 1)'(quality_offset);
    pos_ok = 32'(in_data.position) < MAX_POSITIONS;
    bin_ok = 32'(in_data.quality_char) < SCORE_BINS;

    // Scores below zero land in bin zero, scores past the top bin in the top bin.
    if (diff[QCH_W]) begin
      base_bin = '0;
    end else if (diff[QCH_W-1:0] > QCH_W'(SCORE_BINS - 1)) begin
      base_bin = BIN_W'(SCORE_BINS - 1);
    end else begin
      base_bin = diff[BIN_W-1:0];
    end

    push_op.mate     = in_data.mate;
    push_op.position = in_data.position;
    push_op.bin      = base_bin;
    push_op.hit      = 1'b0;
    push_op.kind     = OP_COUNT;
    keep             = 1'b0;
    unique case (in_data.action)
      ACT_BASE: begin
        keep = pos_ok;
      end
      ACT_READ_END: begin
        push_op.kind = OP_READ_END;
        keep         = 1'b1;
      end
      ACT_QUERY: begin
        push_op.kind = OP_QUERY;
        push_op.bin  = in_data.quality_char[BIN_W-1:0];
        push_op.hit  = pos_ok && bin_ok;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase

    in_stall = clearing | queue_full;
    push     = in_valid & ~in_stall & keep;
  end

endmodule

FILE: rtl/pph_queue.sv
// Short queue of classified items between the front and the back.
module pph_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  pph_pkg::op_t push_op,
  input  logic         pop,
  output pph_pkg::op_t head,
  output logic         empty,
  output logic         full
);
  import pph_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = (fill == '0);
  assign full  = (fill == CNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/pph_back.sv
// Back end: counter memory with read-modify-write, totals and the result register.
module pph_back #(
  parameter int MAX_POSITIONS = pph_pkg::DEF_MAX_POSITIONS,
  parameter int SCORE_BINS    = pph_pkg::DEF_SCORE_BINS,
  parameter int COUNT_WIDTH   = pph_pkg::DEF_COUNT_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  pph_pkg::op_t  head,
  output logic          pop,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_stall,
  output pph_pkg::out_t out_data
);
  import pph_pkg::*;

  localparam int PW     = $clog2(MAX_POSITIONS);
  localparam int BW     = $clog2(SCORE_BINS);
  localparam int ADDR_W = 1 + PW + BW;
  localparam int DEPTH  = 2 ** ADDR_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                    state;
  op_t                       op;
  logic [ADDR_W-1:0]         clear_addr;
  logic [COUNT_WIDTH-1:0]    mem [DEPTH];
  logic [COUNT_WIDTH-1:0]    rd_data;
  logic [COUNT_WIDTH-1:0]    inc_data;
  logic [RESULT_COUNT_W-1:0] count_out;
  logic [READ_TOTAL_W-1:0]   read_total;
  logic [LONGEST_W-1:0]      longest;
  logic [LONGEST_W-1:0]      head_end;
  logic                      paired;
  logic [PW+POS_W-1:0]       head_pos_ext;
  logic [PW+POS_W-1:0]       op_pos_ext;
  logic [BW+BIN_W-1:0]       head_bin_ext;
  logic [BW+BIN_W-1:0]       op_bin_ext;
  logic [ADDR_W-1:0]         head_addr;
  logic [ADDR_W-1:0]         op_addr;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [COUNT_WIDTH-1:0]    mem_wdata;
  logic                      result_load;

  always_comb begin
    head_pos_ext = (PW + POS_W)'(head.position);
    op_pos_ext   = (PW + POS_W)'(op.position);
    head_bin_ext = (BW + BIN_W)'(head.bin);
    op_bin_ext   = (BW + BIN_W)'(op.bin);
    head_addr    = {head.mate, head_pos_ext[PW-1:0], head_bin_ext[BW-1:0]};
    op_addr      = {op.mate, op_pos_ext[PW-1:0], op_bin_ext[BW-1:0]};
    head_end     = LONGEST_W'(head.position) + 1'b1;

    inc_data  = (&rd_data) ? rd_data : rd_data + 1'b1;
    clearing  = (state == ST_CLEAR);
    pop       = (state == ST_IDLE) && !empty;
    mem_we    = clearing || (state == ST_EXEC && op.kind == OP_COUNT);
    mem_waddr = clearing ? clear_addr : op_addr;
    mem_wdata = clearing ? '0 : inc_data;

    // A query result is loaded once the output register is free or leaving.
    result_load = (state == ST_EXEC) && (op.kind == OP_QUERY) && (!out_valid || !out_stall);
  end

  generate
    if (COUNT_WIDTH > RESULT_COUNT_W) begin : g_wide
      assign count_out = (|rd_data[COUNT_WIDTH-1:RESULT_COUNT_W]) ? '1
                                                                  : rd_data[RESULT_COUNT_W-1:0];
    end else begin : g_narrow
      assign count_out = RESULT_COUNT_W'(rd_data);
    end
  endgenerate

  // Single-port counter store; a read is issued only when an item is popped.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data <= mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      read_total <= '0;
      longest    <= '0;
      paired     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (&clear_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            op <= head;
            unique case (head.kind)
              OP_COUNT: begin
                if (head_end > longest) begin
                  longest <= head_end;
                end
                paired <= paired | head.mate;
                state  <= ST_EXEC;
              end
              OP_READ_END: begin
                if (!(&read_total)) begin
                  read_total <= read_total + 1'b1;
                end
                paired <= paired | head.mate;
              end
              OP_QUERY: begin
                state <= ST_EXEC;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_EXEC: begin
          if (op.kind == OP_QUERY) begin
            if (result_load) begin
              out_data.bin_count    <= op.hit ? count_out : '0;
              out_data.read_total   <= read_total;
              out_data.longest_read <= longest;
              out_data.paired_seen  <= paired;
              state                 <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/per_position_quality_histogram.sv
// Per-position quality histogram: one score histogram per mate and base position.
//
// Each input beat carries an action: count one base, end one read, or query one
// bin. A counted base lands in the bin of its quality character minus the
// quality_offset register (reset 33), clamped to bin zero and to the top bin,
// and that counter saturates at its full value. Bases at or beyond
// MAX_POSITIONS are dropped, as is the unused action code. A query returns one
// output beat with the bin count (saturated to 32 bits), the saturating read
// total, the longest position seen plus one and the second-mate flag; an
// out-of-range query position or bin reads as a count of zero. The front end
// accepts one beat per cycle into a four-entry queue unless that queue is
// full, so bursts are absorbed; the back end handles one item at a time
// through the counter memory's single port: a base is read, then its
// incremented count written back; an end of read needs no memory access; a
// query reads its counter, then waits while an earlier output beat is held
// by out_stall. After reset the back end sweeps all 2 * 2**clog2(MAX_POSITIONS) *
// 2**clog2(SCORE_BINS) counter entries (65536 with the defaults) to zero, one
// entry per cycle; in_stall stays high for that whole sweep, while configuration
// writes are still taken. Write the offset only when no item is outstanding.
module per_position_quality_histogram #(
  parameter int MAX_POSITIONS = pph_pkg::DEF_MAX_POSITIONS,
  parameter int SCORE_BINS    = pph_pkg::DEF_SCORE_BINS,
  parameter int COUNT_WIDTH   = pph_pkg::DEF_COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pph_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pph_pkg::out_t                out_data,
  input  logic                         cfg_write,
  input  logic [pph_pkg::OFFSET_W-1:0] cfg_data
);
  import pph_pkg::*;

  logic clearing;
  logic queue_full;
  logic queue_empty;
  logic push;
  logic pop;
  op_t  push_op;
  op_t  head;

  // Classification happens on the accepting edge, using the current offset.
  pph_front #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .SCORE_BINS   (SCORE_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .queue_full(queue_full),
    .push      (push),
    .push_op   (push_op)
  );

  pph_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head   (head),
    .empty  (queue_empty),
    .full   (queue_full)
  );

  // Items execute strictly in order, so a query sees every earlier item.
  pph_back #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .SCORE_BINS   (SCORE_BINS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (queue_empty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

FILE: rtl/pph_checker.sv
// Port-level assertions for the per-position quality histogram, bound to the top level.
module pph_checker #(
  parameter int MAX_POSITIONS = pph_pkg::DEF_MAX_POSITIONS
) (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input pph_pkg::out_t out_data
);
  import pph_pkg::*;

  // The counter sweep after reset holds off input.
  a_clear_after_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> in_stall)
    else $error("input accepted during the clearing sweep");

  a_no_result_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result beat dropped");

  a_longest_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.longest_read) <= MAX_POSITIONS))
    else $error("longest read beyond the position range");

endmodule

bind per_position_quality_histogram pph_checker #(
  .MAX_POSITIONS(MAX_POSITIONS)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
